// ----- rtl/core/sdau_pkg.sv -----
// ---------------------------------------------------------------------------
// sdau_pkg: shared types and constants
// Mode codes, sequencer states, digit helpers for the serial decimal unit.
// ---------------------------------------------------------------------------
package sdau_pkg;

	localparam int MAX_DIGITS_DEF = 256;
	localparam int DIGIT_W        = 4;
	localparam int DIV_BASE       = 10;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_MUL   = 2'd1,
		ST_DRAIN = 2'd2,
		ST_DONE  = 2'd3
	} state_t;

	// clamp a raw nibble to a decimal digit
	function automatic logic [DIGIT_W-1:0] sat_digit(input logic [DIGIT_W-1:0] v);
		logic [DIGIT_W-1:0] nine;
		nine = DIGIT_W'(DIV_BASE - 1);
		return (v > nine) ? nine : v;
	endfunction

endpackage

// ----- rtl/core/sdau_ram.sv -----
// ---------------------------------------------------------------------------
// sdau_ram: digit store
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module sdau_ram #(
	parameter int DEPTH = sdau_pkg::MAX_DIGITS_DEF,
	parameter int WIDTH = sdau_pkg::DIGIT_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/sdau_div10.sv -----
// ---------------------------------------------------------------------------
// sdau_div10: divide by ten
// Reciprocal multiply, then one compare-and-subtract correction.
// ---------------------------------------------------------------------------
module sdau_div10 #(
	parameter int XW = 15
) (
	input  logic [XW-1:0]                x,
	output logic [XW-4:0]                q,
	output logic [sdau_pkg::DIGIT_W-1:0] r
);
	import sdau_pkg::*;

	localparam int SH = XW + 4;
	localparam int RW = SH - 3;
	localparam int QW = XW - 3;
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << SH) / 64'(DIV_BASE));

	logic [XW+RW-1:0] prod;
	logic [QW-1:0]    q_est;
	logic [XW-1:0]    rem;

	// estimate is exact or one low
	assign prod  = (XW+RW)'(x) * (XW+RW)'(RECIP);
	assign q_est = prod[XW+RW-1:SH];
	assign rem   = x - XW'(q_est) * XW'(DIV_BASE);

	always_comb begin
		if (rem >= XW'(DIV_BASE)) begin
			q = q_est + QW'(1);
			r = DIGIT_W'(rem - XW'(DIV_BASE));
		end else begin
			q = q_est;
			r = DIGIT_W'(rem);
		end
	end

endmodule

// ----- rtl/core/serial_decimal_arithmetic_unit.sv -----
// ---------------------------------------------------------------------------
// serial_decimal_arithmetic_unit: digit-serial BCD add / subtract / multiply
// Order: an add/sub word goes through acc_q, then the output register; a multiply
//   makes k+1 store reads at position k, one drain, then one divide.
// Flow: one word is taken at a time, the next only once the last result is
//   registered; a multiply is paced by the single read port of each digit store.
// Reset: arst_n clears position, carry, mode (add) and output valid and sets the
//   order flag at once; the digit stores are not cleared and need no sweep.
// ---------------------------------------------------------------------------
module serial_decimal_arithmetic_unit #(
	parameter int MAX_DIGITS = sdau_pkg::MAX_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// config: mode register
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [3:0] digit_a, [7:4] digit_b
	input  logic       s_tlast,   // final_digit
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [3:0] result_digit, [7:4] zero
	output logic       m_tuser,   // a_not_less
	output logic       m_tlast    // end_of_number
);
	import sdau_pkg::*;

	localparam int PW = $clog2(MAX_DIGITS + 1);      // position, holds MAX_DIGITS
	localparam int IW = $clog2(MAX_DIGITS);          // store index
	localparam int CW = $clog2(9 * MAX_DIGITS + 1);  // carry never exceeds 9*N
	localparam int AW = $clog2(90 * MAX_DIGITS + 1); // carry + 81 per term
	localparam int QW = AW - 3;

	// control state
	state_t          state_q, state_d;
	mode_t           mode_q;
	logic [PW-1:0]   pos_q;
	logic [CW-1:0]   carry_q;
	logic            flag_q;
	logic            m_valid_q;
	logic            rdv_s1;

	// per-word payload
	logic [IW-1:0]      k_q;
	logic [IW-1:0]      i_q;
	logic [AW-1:0]      acc_q;
	logic               last_q;
	logic               inrange_q;
	logic [DIGIT_W-1:0] digit_q;
	logic               user_q;
	logic               tlast_q;

	// input decode
	logic [DIGIT_W-1:0] in_a, in_b;
	logic               accept, in_range, out_free;
	logic [DIGIT_W:0]   sub_w;

	// store ports
	logic [DIGIT_W-1:0] rd_a, rd_b;
	logic [IW-1:0]      raddr_b;
	logic [2*DIGIT_W-1:0] prod;

	// divider
	logic [QW-1:0]      div_q;
	logic [DIGIT_W-1:0] div_r;

	assign in_a     = sat_digit(s_tdata[DIGIT_W-1:0]);
	assign in_b     = sat_digit(s_tdata[2*DIGIT_W-1:DIGIT_W]);
	assign accept   = s_tvalid && s_tready;
	assign in_range = pos_q < PW'(MAX_DIGITS);
	assign out_free = !m_valid_q || m_tready;
	// subtrahend including the borrow; any nonzero carry borrows one
	assign sub_w    = {1'b0, in_b} + (DIGIT_W+1)'(carry_q != '0);
	assign raddr_b  = k_q - i_q;
	assign prod     = rd_a * rd_b;

	// both stores written at the current position on an in-range accept
	sdau_ram #(.DEPTH(MAX_DIGITS), .WIDTH(DIGIT_W)) u_ram_a (
		.clk   (clk),
		.we    (accept && in_range),
		.waddr (pos_q[IW-1:0]),
		.wdata (in_a),
		.raddr (i_q),
		.rdata (rd_a)
	);

	sdau_ram #(.DEPTH(MAX_DIGITS), .WIDTH(DIGIT_W)) u_ram_b (
		.clk   (clk),
		.we    (accept && in_range),
		.waddr (pos_q[IW-1:0]),
		.wdata (in_b),
		.raddr (raddr_b),
		.rdata (rd_b)
	);

	sdau_div10 #(.XW(AW)) u_div (
		.x (acc_q),
		.q (div_q),
		.r (div_r)
	);

	// sequencer: next state and handshake
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_range && mode_q == MODE_MUL) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MUL: begin
				if (i_q == k_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_ADD;
			pos_q     <= '0;
			carry_q   <= '0;
			flag_q    <= 1'b1;
			m_valid_q <= 1'b0;
			rdv_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= mode_t'(cfg_wdata);
			end
			// a read is in flight for every issue cycle
			rdv_s1 <= (state_q == ST_MUL);
			if (accept && in_range) begin
				if (in_a > in_b) begin
					flag_q <= 1'b1;
				end else if (in_a < in_b) begin
					flag_q <= 1'b0;
				end
			end
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
				if (last_q) begin
					pos_q   <= '0;
					carry_q <= '0;
					flag_q  <= 1'b1;
				end else if (inrange_q) begin
					pos_q   <= PW'(k_q) + PW'(1);
					carry_q <= CW'(div_q);
				end
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			k_q       <= pos_q[IW-1:0];
			i_q       <= '0;
			last_q    <= s_tlast;
			inrange_q <= in_range;
			if (!in_range) begin
				acc_q <= '0;  // overflow digits give zero
			end else begin
				case (mode_q)
					MODE_SUB: begin
						// borrow case biased by twenty so the divider yields carry one
						if ({1'b0, in_a} < sub_w) begin
							acc_q <= AW'(in_a) + AW'(2 * DIV_BASE) - AW'(sub_w);
						end else begin
							acc_q <= AW'(in_a) - AW'(sub_w);
						end
					end
					MODE_MUL: acc_q <= AW'(carry_q);
					default:  acc_q <= AW'(in_a) + AW'(in_b) + AW'(carry_q);
				endcase
			end
		end else begin
			if (state_q == ST_MUL && i_q != k_q) begin
				i_q <= i_q + IW'(1);
			end
			// convolution term a[i] * b[k-i]
			if (rdv_s1) begin
				acc_q <= acc_q + AW'(prod);
			end
		end
		if (state_q == ST_DONE && out_free) begin
			digit_q <= div_r;
			user_q  <= last_q && flag_q;
			tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(8 - DIGIT_W)'(0), digit_q};
	assign m_tuser  = user_q;
	assign m_tlast  = tlast_q;

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !rdv_s1)
		else $error("input taken while a store read is in flight");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] <= 4'd9))
		else $error("result digit not decimal");

	a_user_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("order flag set off the final digit");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_DIGITS))
		else $error("digit position past maximum");

	a_carry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		carry_q <= CW'(9 * MAX_DIGITS))
		else $error("running carry out of bound");

endmodule
